// ===== hw/rtl/alist_pkg.sv =====
// ============================================================================
// alist_pkg - shared types and constants of the array list block
// Field widths, operation codes, the sequencer states and the command and
// status bundles between the controller and the datapath.
// ============================================================================
package alist_pkg;

    // Transaction field widths
    localparam int MODE_W = 3;
    localparam int POS_W  = 5;
    localparam int VAL_W  = 32;
    localparam int LEN_W  = 5;

    // Input tdata layout, lowest bit first
    localparam int IN_MODE_LSB = 0;
    localparam int IN_POS_LSB  = IN_MODE_LSB + MODE_W;
    localparam int IN_VAL_LSB  = IN_POS_LSB + POS_W;
    localparam int IN_TDATA_W  = ((IN_VAL_LSB + VAL_W + 7) / 8) * 8;

    // Output tdata layout, lowest bit first
    localparam int OUT_USED_W  = 1 + POS_W + VAL_W + LEN_W;
    localparam int OUT_TDATA_W = ((OUT_USED_W + 7) / 8) * 8;
    localparam int OUT_PAD_W   = OUT_TDATA_W - OUT_USED_W;

    typedef enum logic [MODE_W-1:0] {
        MODE_INSERT = 3'd0,
        MODE_DELETE = 3'd1,
        MODE_LOCATE = 3'd2,
        MODE_GET    = 3'd3,
        MODE_CLEAR  = 3'd4
    } mode_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHECK,
        S_UP,
        S_UP_TAIL,
        S_WRVAL,
        S_DN,
        S_DN_TAIL,
        S_SCAN,
        S_SCAN_LAST,
        S_GET,
        S_DONE
    } state_t;

    typedef enum logic [2:0] {
        IDX_HOLD,
        IDX_INC,
        IDX_DEC,
        IDX_TOP,
        IDX_POS,
        IDX_POSM1,
        IDX_ZERO
    } idx_op_t;

    typedef enum logic [1:0] {
        WR_NONE,
        WR_UP,
        WR_DN,
        WR_VALUE
    } wr_op_t;

    typedef enum logic [1:0] {
        CNT_HOLD,
        CNT_INC,
        CNT_DEC,
        CNT_CLR
    } cnt_op_t;

    typedef struct packed {
        logic    load;
        logic    ok_load;
        logic    rd_en;
        logic    found_load;
        logic    res_load;
        idx_op_t idx_op;
        wr_op_t  wr_op;
        cnt_op_t cnt_op;
    } cmd_t;

    typedef struct packed {
        mode_t mode;
        logic  op_ok;
        logic  append;
        logic  del_tail;
        logic  cnt_zero;
        logic  idx_at_pos;
        logic  idx_at_top;
        logic  match;
        logic  out_free;
    } sts_t;

endpackage

// ===== hw/rtl/alist_dp.sv =====
// ============================================================================
// alist_dp - array list datapath
// Entry memory with one write and one registered read port, the length
// counter, the scan index, the operation registers and the result register.
// ============================================================================
module alist_dp
    import alist_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    input  logic                   m_axis_tready,
    output logic                   m_axis_tvalid,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input  cmd_t                   cmd,
    output sts_t                   sts
);

    localparam int AW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);
    localparam int WW = ((CW > POS_W) ? CW : POS_W) + 1;

    logic [VAL_W-1:0] mem [DEPTH];

    mode_t            mode_reg;
    logic [POS_W-1:0] pos_reg;
    logic [VAL_W-1:0] val_reg;
    logic [CW-1:0]    count_reg, count_next;
    logic [AW-1:0]    idx_reg, idx_next;
    logic [AW-1:0]    rd_addr_reg;
    logic [VAL_W-1:0] rd_data_reg;
    logic             rd_vld_reg;
    logic             ok_reg;
    logic [POS_W-1:0] found_reg;
    logic             out_vld_reg;
    logic [OUT_TDATA_W-1:0] out_data_reg;

    logic [WW-1:0]    pos_w, pos_m1_w, cnt_w, cnt_m1_w, idx_w, fnd_w;
    logic             ok_ins, ok_rd, op_ok;
    logic             wr_en;
    logic [AW-1:0]    wr_addr;
    logic [VAL_W-1:0] wr_data;
    logic [VAL_W-1:0] rd_result;

    assign pos_w    = WW'(pos_reg);
    assign pos_m1_w = pos_w - WW'(1);
    assign cnt_w    = WW'(count_reg);
    assign cnt_m1_w = cnt_w - WW'(1);
    assign idx_w    = WW'(idx_reg);
    assign fnd_w    = WW'(rd_addr_reg) + WW'(1);

    assign ok_ins = (pos_w != '0) && (pos_w <= cnt_w + WW'(1)) && (cnt_w < WW'(DEPTH));
    assign ok_rd  = (pos_w != '0) && (pos_w <= cnt_w);

    always_comb
    begin
        case (mode_reg)
            MODE_INSERT: op_ok = ok_ins;
            MODE_DELETE: op_ok = ok_rd;
            MODE_LOCATE: op_ok = 1'b1;
            MODE_GET:    op_ok = ok_rd;
            MODE_CLEAR:  op_ok = 1'b1;
            default:     op_ok = 1'b0;
        endcase
    end

    assign sts.mode       = mode_reg;
    assign sts.op_ok      = op_ok;
    assign sts.append     = (pos_m1_w == cnt_w);
    assign sts.del_tail   = (pos_w == cnt_w);
    assign sts.cnt_zero   = (count_reg == '0);
    assign sts.idx_at_pos = (idx_w == pos_m1_w);
    assign sts.idx_at_top = (idx_w == cnt_m1_w);
    assign sts.match      = rd_vld_reg && (rd_data_reg == val_reg);
    assign sts.out_free   = !out_vld_reg || m_axis_tready;

    // Shift moves write back the entry read in the previous cycle, one slot over.
    always_comb
    begin
        wr_en   = 1'b0;
        wr_addr = rd_addr_reg;
        wr_data = rd_data_reg;
        case (cmd.wr_op)
            WR_UP:
            begin
                wr_en   = rd_vld_reg;
                wr_addr = rd_addr_reg + AW'(1);
            end
            WR_DN:
            begin
                wr_en   = rd_vld_reg;
                wr_addr = rd_addr_reg - AW'(1);
            end
            WR_VALUE:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_m1_w[AW-1:0];
                wr_data = val_reg;
            end
            default:
            begin
                wr_en = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.rd_en)
        begin
            rd_data_reg <= mem[idx_reg];
            rd_addr_reg <= idx_reg;
        end
    end

    always_comb
    begin
        case (cmd.cnt_op)
            CNT_INC: count_next = count_reg + CW'(1);
            CNT_DEC: count_next = count_reg - CW'(1);
            CNT_CLR: count_next = '0;
            default: count_next = count_reg;
        endcase
    end

    always_comb
    begin
        case (cmd.idx_op)
            IDX_INC:   idx_next = idx_reg + AW'(1);
            IDX_DEC:   idx_next = idx_reg - AW'(1);
            IDX_TOP:   idx_next = cnt_m1_w[AW-1:0];
            IDX_POS:   idx_next = pos_w[AW-1:0];
            IDX_POSM1: idx_next = pos_m1_w[AW-1:0];
            IDX_ZERO:  idx_next = '0;
            default:   idx_next = idx_reg;
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            mode_reg <= mode_t'(s_axis_tdata[IN_MODE_LSB +: MODE_W]);
            pos_reg  <= s_axis_tdata[IN_POS_LSB +: POS_W];
            val_reg  <= s_axis_tdata[IN_VAL_LSB +: VAL_W];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg  <= '0;
            idx_reg    <= '0;
            rd_vld_reg <= 1'b0;
            ok_reg     <= 1'b0;
            found_reg  <= '0;
        end
        else
        begin
            count_reg  <= count_next;
            idx_reg    <= idx_next;
            rd_vld_reg <= cmd.rd_en;
            if (cmd.ok_load)
            begin
                ok_reg <= op_ok;
            end
            if (cmd.load)
            begin
                found_reg <= '0;
            end
            else if (cmd.found_load && sts.match)
            begin
                found_reg <= fnd_w[POS_W-1:0];
            end
        end
    end

    assign rd_result = (mode_reg == MODE_GET && ok_reg) ? rd_data_reg : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (cmd.res_load)
        begin
            out_vld_reg <= 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.res_load)
        begin
            out_data_reg <= {{OUT_PAD_W{1'b0}}, cnt_w[LEN_W-1:0], rd_result,
                             found_reg, ok_reg};
        end
    end

    assign m_axis_tvalid = out_vld_reg;
    assign m_axis_tdata  = out_data_reg;

endmodule

// ===== hw/rtl/alist_ctrl.sv =====
// ============================================================================
// alist_ctrl - array list sequencer
// State machine that checks each operation and then steps the datapath
// through the entry moves, the search or the read that it needs.
// ============================================================================
module alist_ctrl
    import alist_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic s_axis_tvalid,
    output logic s_axis_tready,
    input  sts_t sts,
    output cmd_t cmd
);

    state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next     = state_reg;
        s_axis_tready  = 1'b0;
        cmd.load       = 1'b0;
        cmd.ok_load    = 1'b0;
        cmd.rd_en      = 1'b0;
        cmd.found_load = 1'b0;
        cmd.res_load   = 1'b0;
        cmd.idx_op     = IDX_HOLD;
        cmd.wr_op      = WR_NONE;
        cmd.cnt_op     = CNT_HOLD;

        case (state_reg)
            S_IDLE:
            begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end

            S_CHECK:
            begin
                cmd.ok_load = 1'b1;
                state_next  = S_DONE;
                case (sts.mode)
                    MODE_INSERT:
                    begin
                        if (sts.op_ok && sts.append)
                        begin
                            state_next = S_WRVAL;
                        end
                        else if (sts.op_ok)
                        begin
                            cmd.idx_op = IDX_TOP;
                            state_next = S_UP;
                        end
                    end
                    MODE_DELETE:
                    begin
                        if (sts.op_ok && sts.del_tail)
                        begin
                            cmd.cnt_op = CNT_DEC;
                        end
                        else if (sts.op_ok)
                        begin
                            cmd.idx_op = IDX_POS;
                            state_next = S_DN;
                        end
                    end
                    MODE_LOCATE:
                    begin
                        if (!sts.cnt_zero)
                        begin
                            cmd.idx_op = IDX_ZERO;
                            state_next = S_SCAN;
                        end
                    end
                    MODE_GET:
                    begin
                        if (sts.op_ok)
                        begin
                            cmd.idx_op = IDX_POSM1;
                            state_next = S_GET;
                        end
                    end
                    MODE_CLEAR:
                    begin
                        cmd.cnt_op = CNT_CLR;
                    end
                    default:
                    begin
                        state_next = S_DONE;
                    end
                endcase
            end

            // Walk down from the top entry, moving each one a slot up.
            S_UP:
            begin
                cmd.rd_en = 1'b1;
                cmd.wr_op = WR_UP;
                if (sts.idx_at_pos)
                begin
                    state_next = S_UP_TAIL;
                end
                else
                begin
                    cmd.idx_op = IDX_DEC;
                end
            end

            S_UP_TAIL:
            begin
                cmd.wr_op  = WR_UP;
                state_next = S_WRVAL;
            end

            S_WRVAL:
            begin
                cmd.wr_op  = WR_VALUE;
                cmd.cnt_op = CNT_INC;
                state_next = S_DONE;
            end

            // Walk up from the entry after the gap, moving each one a slot down.
            S_DN:
            begin
                cmd.rd_en = 1'b1;
                cmd.wr_op = WR_DN;
                if (sts.idx_at_top)
                begin
                    state_next = S_DN_TAIL;
                end
                else
                begin
                    cmd.idx_op = IDX_INC;
                end
            end

            S_DN_TAIL:
            begin
                cmd.wr_op  = WR_DN;
                cmd.cnt_op = CNT_DEC;
                state_next = S_DONE;
            end

            // The compare looks at the entry read in the previous cycle.
            S_SCAN:
            begin
                cmd.found_load = 1'b1;
                if (sts.match)
                begin
                    state_next = S_DONE;
                end
                else
                begin
                    cmd.rd_en = 1'b1;
                    if (sts.idx_at_top)
                    begin
                        state_next = S_SCAN_LAST;
                    end
                    else
                    begin
                        cmd.idx_op = IDX_INC;
                    end
                end
            end

            S_SCAN_LAST:
            begin
                cmd.found_load = 1'b1;
                state_next     = S_DONE;
            end

            S_GET:
            begin
                cmd.rd_en  = 1'b1;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (sts.out_free)
                begin
                    cmd.res_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/array_list_insert_delete_locate.sv =====
// ============================================================================
// array_list_insert_delete_locate - ordered list of signed 32-bit entries
// Insert, delete, locate, get and clear on a list of up to DEPTH entries,
// one result transaction for each input transaction.
// ============================================================================
//
//  Channel  Direction  tdata fields (lowest bit first)
//  s_axis   in         mode[2:0], position[7:3], value[39:8]
//  m_axis   out        ok[0], found_position[5:1], read_value[37:6],
//                      length[42:38], zero[47:43]
//
//  One operation is in work at a time; the entry memory moves one entry per
//  cycle through its one read port and its one write port. Insert and delete
//  shift the entries behind the position, locate scans from the first entry
//  until a match or the last entry, and get reads one entry. A stalled result
//  holds the sequencer in its final state. Reset empties the list; entry
//  contents stay unknown.
//
module array_list_insert_delete_locate
    import alist_pkg::*;
#(
    parameter int DEPTH = 16
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // mode, position, value
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    output logic [OUT_TDATA_W-1:0] m_axis_tdata    // ok, found_position, read_value,
                                                   // length, zero pad
);

    cmd_t cmd;
    sts_t sts;

    alist_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .sts           (sts),
        .cmd           (cmd)
    );

    alist_dp #(
        .DEPTH (DEPTH)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tready (m_axis_tready),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tdata  (m_axis_tdata),
        .cmd           (cmd),
        .sts           (sts)
    );

endmodule

// ===== hw/rtl/alist_checker.sv =====
// ============================================================================
// alist_checker - port-level checks of the array list block
// Watches the stream ports and flags results that break the block's rules.
// ============================================================================
module alist_checker
    import alist_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata
);

    // A stalled result stays put.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
        else $error("result changed while stalled");

    // Only one operation is in work, so ready drops right after a transaction.
    assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
        else $error("input taken while an operation is in work");

    // A failed operation reports neither a position nor a read value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tdata[0] |-> m_axis_tdata[37:1] == '0)
        else $error("failed operation carries data");

    // A found position comes only from locate, which reads no value.
    assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && m_axis_tdata[5:1] != '0 |-> m_axis_tdata[37:6] == '0)
        else $error("found position and read value together");

endmodule

bind array_list_insert_delete_locate alist_checker u_alist_checker (.*);
